// File: rtl/pcse_pkg.sv
// Shared types and constants for the PCI configuration space enumerator.
// No dependencies; pcse_walk, pcse_rsp_fifo and the top take names from here by scope.
package pcse_pkg;

   // result kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // pending read phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_ID   = 3'd2;
   localparam logic [2:0] PH_REV  = 3'd3;
   localparam logic [2:0] PH_BASE = 3'd4;
   localparam logic [2:0] PH_IRQ  = 3'd5;
   localparam logic [2:0] PH_PIN  = 3'd6;

   // request command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // access sizes
   localparam logic SIZE_BYTE  = 1'b0;
   localparam logic SIZE_DWORD = 1'b1;

   // configuration header offsets
   localparam logic [7:0] REG_ID     = 8'h00;
   localparam logic [7:0] REG_REV    = 8'h08;
   localparam logic [7:0] REG_HDR    = 8'h0E;
   localparam logic [7:0] REG_BASE0  = 8'h10;
   localparam logic [7:0] REG_IRQ    = 8'h3C;
   localparam logic [7:0] REG_PIN    = 8'h3D;

   // field indexes
   localparam logic [3:0] FI_ID    = 4'd0;
   localparam logic [3:0] FI_REV   = 4'd1;
   localparam logic [3:0] FI_BASE0 = 4'd2;
   localparam logic [3:0] FI_IRQ   = 4'd8;
   localparam logic [3:0] FI_PIN   = 4'd9;

   localparam logic [8:0] BUS_LIMIT_RESET = 9'd8;
   localparam logic [8:0] BUS_LIMIT_MAX   = 9'd256;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;

   typedef struct packed {
      logic [8:0] scan_bus;
      logic [7:0] scan_devfn;
      logic [7:0] header_type;
      logic [2:0] pending_phase;
      logic [2:0] bar_slot;
   } walk_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] config_address;
      logic [1:0]  byte_lane;
      logic        access_size;
      logic [3:0]  field_index;
      logic [31:0] field_value;
      logic        last;
   } rsp_item_type;

endpackage

// File: rtl/pcse_req_if.sv
// Request channel of the enumerator: valid/ready handshake plus payload.
// No dependencies.
interface pcse_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] read_data;
   logic        read_failed;

   modport source (output valid, cmd, read_data, read_failed, input ready);
   modport sink   (input valid, cmd, read_data, read_failed, output ready);
endinterface

// File: rtl/pcse_rsp_if.sv
// Result channel of the enumerator: valid/ready handshake plus payload.
// No dependencies.
interface pcse_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] config_address;
   logic [1:0]  byte_lane;
   logic        access_size;
   logic [3:0]  field_index;
   logic [31:0] field_value;
   logic        last;

   modport source (output valid, kind, config_address, byte_lane, access_size,
                   field_index, field_value, last, input ready);
   modport sink   (input valid, kind, config_address, byte_lane, access_size,
                   field_index, field_value, last, output ready);
endinterface

// File: rtl/pcse_walk.sv
// Combinational step of the scan walk: next state and up to two results.
// Depends on pcse_pkg.
module pcse_walk #(
   parameter int BASE_COUNT = 6
) (
   input  pcse_pkg::walk_state_type state_cur,
   input  logic                     cmd,
   input  logic [31:0]              read_data,
   input  logic                     read_failed,
   input  logic [8:0]               bus_limit,
   output pcse_pkg::walk_state_type state_nxt,
   output logic [1:0]               res_count,
   output pcse_pkg::rsp_item_type   res0,
   output pcse_pkg::rsp_item_type   res1
);

   localparam logic [3:0] BaseLimit = 4'(BASE_COUNT);

   function automatic logic [31:0] cfg_addr(input logic [8:0] bus,
                                            input logic [7:0] devfn,
                                            input logic [7:0] rg);
      cfg_addr = {1'b1, 7'd0, bus[7:0], devfn, rg[7:2], 2'b00};
   endfunction

   function automatic pcse_pkg::rsp_item_type mk_read(input logic [8:0] bus,
                                                      input logic [7:0] devfn,
                                                      input logic [7:0] rg,
                                                      input logic       size);
      pcse_pkg::rsp_item_type r;
      r.kind           = pcse_pkg::KIND_READ;
      r.config_address = cfg_addr(bus, devfn, rg);
      r.byte_lane      = size ? 2'd0 : rg[1:0];
      r.access_size    = size;
      r.field_index    = 4'd0;
      r.field_value    = 32'd0;
      r.last           = 1'b0;
      mk_read = r;
   endfunction

   function automatic pcse_pkg::rsp_item_type mk_report(input logic [8:0]  bus,
                                                        input logic [7:0]  devfn,
                                                        input logic [7:0]  rg,
                                                        input logic [1:0]  lane,
                                                        input logic        size,
                                                        input logic [3:0]  fi,
                                                        input logic [31:0] fv);
      pcse_pkg::rsp_item_type r;
      r.kind           = pcse_pkg::KIND_REPORT;
      r.config_address = cfg_addr(bus, devfn, rg);
      r.byte_lane      = lane;
      r.access_size    = size;
      r.field_index    = fi;
      r.field_value    = fv;
      r.last           = 1'b0;
      mk_report = r;
   endfunction

   function automatic pcse_pkg::rsp_item_type mk_status(input logic [1:0] kind);
      pcse_pkg::rsp_item_type r;
      r       = '0;
      r.kind  = kind;
      mk_status = r;
   endfunction

   logic [8:0]  eff_limit;
   logic [31:0] byte_val;
   logic [8:0]  nxt_raw;
   logic [8:0]  wrap_bus;
   logic        walk_done;
   logic [8:0]  walk_bus;
   logic [7:0]  walk_devfn;
   logic [2:0]  walk_phase;
   pcse_pkg::rsp_item_type walk_res;
   logic [2:0]  base_nxt;
   logic [7:0]  base_reg;
   logic [7:0]  base_reg_nxt;
   logic [3:0]  base_fi;

   assign eff_limit = (bus_limit > pcse_pkg::BUS_LIMIT_MAX) ? pcse_pkg::BUS_LIMIT_MAX
                                                            : bus_limit;
   assign byte_val  = {24'd0, read_data[7:0]};

   // next function, or next device when the device is single-function
   always_comb begin
      nxt_raw = state_cur.header_type[7] ? ({1'b0, state_cur.scan_devfn} + 9'd1)
                                         : ({1'b0, state_cur.scan_devfn | 8'h07} + 9'd1);
      wrap_bus = state_cur.scan_bus + 9'd1;
      walk_done  = 1'b0;
      walk_bus   = state_cur.scan_bus;
      walk_devfn = nxt_raw[7:0];
      walk_phase = pcse_pkg::PH_HDR;
      if (nxt_raw[8]) begin
         walk_bus   = wrap_bus;
         walk_devfn = 8'd0;
         walk_done  = (wrap_bus >= eff_limit);
      end
      if (walk_done) begin
         walk_phase = pcse_pkg::PH_IDLE;
         walk_res   = mk_status(pcse_pkg::KIND_DONE);
      end else if (walk_devfn[2:0] == 3'd0) begin
         walk_phase = pcse_pkg::PH_HDR;
         walk_res   = mk_read(walk_bus, walk_devfn, pcse_pkg::REG_HDR, pcse_pkg::SIZE_BYTE);
      end else begin
         walk_phase = pcse_pkg::PH_ID;
         walk_res   = mk_read(walk_bus, walk_devfn, pcse_pkg::REG_ID, pcse_pkg::SIZE_DWORD);
      end
   end

   assign base_nxt     = state_cur.bar_slot + 3'd1;
   assign base_reg     = pcse_pkg::REG_BASE0 + {3'd0, state_cur.bar_slot, 2'b00};
   assign base_reg_nxt = pcse_pkg::REG_BASE0 + {3'd0, base_nxt, 2'b00};
   assign base_fi      = pcse_pkg::FI_BASE0 + {1'b0, state_cur.bar_slot};

   always_comb begin
      state_nxt = state_cur;
      res_count = 2'd0;
      res0      = mk_status(pcse_pkg::KIND_DONE);
      res1      = mk_status(pcse_pkg::KIND_DONE);
      if (cmd == pcse_pkg::CMD_START) begin
         state_nxt.scan_bus    = 9'd0;
         state_nxt.scan_devfn  = 8'd0;
         state_nxt.header_type = 8'd0;
         state_nxt.bar_slot    = 3'd0;
         res_count = 2'd1;
         if (eff_limit == 9'd0) begin
            state_nxt.pending_phase = pcse_pkg::PH_IDLE;
            res0 = mk_status(pcse_pkg::KIND_DONE);
         end else begin
            state_nxt.pending_phase = pcse_pkg::PH_HDR;
            res0 = mk_read(9'd0, 8'd0, pcse_pkg::REG_HDR, pcse_pkg::SIZE_BYTE);
         end
      end else if (state_cur.pending_phase == pcse_pkg::PH_IDLE ||
                   state_cur.pending_phase > pcse_pkg::PH_PIN) begin
         res_count = 2'd0;
      end else if (read_failed) begin
         state_nxt.pending_phase = pcse_pkg::PH_IDLE;
         res_count = 2'd1;
         res0 = mk_status(pcse_pkg::KIND_ERROR);
      end else begin
         case (state_cur.pending_phase)
            pcse_pkg::PH_HDR: begin
               state_nxt.header_type   = read_data[7:0];
               state_nxt.pending_phase = pcse_pkg::PH_ID;
               res_count = 2'd1;
               res0 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                              pcse_pkg::REG_ID, pcse_pkg::SIZE_DWORD);
            end
            pcse_pkg::PH_ID: begin
               if (read_data != 32'hFFFF_FFFF && read_data != 32'd0) begin
                  state_nxt.pending_phase = pcse_pkg::PH_REV;
                  res_count = 2'd2;
                  res0 = mk_report(state_cur.scan_bus, state_cur.scan_devfn,
                                   pcse_pkg::REG_ID, 2'd0, pcse_pkg::SIZE_DWORD,
                                   pcse_pkg::FI_ID, read_data);
                  res1 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                                 pcse_pkg::REG_REV, pcse_pkg::SIZE_BYTE);
               end else begin
                  state_nxt.scan_bus      = walk_bus;
                  state_nxt.scan_devfn    = walk_devfn;
                  state_nxt.pending_phase = walk_phase;
                  res_count = 2'd1;
                  res0 = walk_res;
               end
            end
            pcse_pkg::PH_REV: begin
               state_nxt.bar_slot      = 3'd0;
               state_nxt.pending_phase = pcse_pkg::PH_BASE;
               res_count = 2'd2;
               res0 = mk_report(state_cur.scan_bus, state_cur.scan_devfn,
                                pcse_pkg::REG_REV, 2'd0, pcse_pkg::SIZE_BYTE,
                                pcse_pkg::FI_REV, byte_val);
               res1 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                              pcse_pkg::REG_BASE0, pcse_pkg::SIZE_DWORD);
            end
            pcse_pkg::PH_BASE: begin
               state_nxt.bar_slot = base_nxt;
               res_count = 2'd2;
               res0 = mk_report(state_cur.scan_bus, state_cur.scan_devfn, base_reg, 2'd0,
                                pcse_pkg::SIZE_DWORD, base_fi, read_data);
               if ({1'b0, base_nxt} < BaseLimit) begin
                  state_nxt.pending_phase = pcse_pkg::PH_BASE;
                  res1 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                                 base_reg_nxt, pcse_pkg::SIZE_DWORD);
               end else begin
                  state_nxt.pending_phase = pcse_pkg::PH_IRQ;
                  res1 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                                 pcse_pkg::REG_IRQ, pcse_pkg::SIZE_BYTE);
               end
            end
            pcse_pkg::PH_IRQ: begin
               state_nxt.pending_phase = pcse_pkg::PH_PIN;
               res_count = 2'd2;
               res0 = mk_report(state_cur.scan_bus, state_cur.scan_devfn,
                                pcse_pkg::REG_IRQ, 2'd0, pcse_pkg::SIZE_BYTE,
                                pcse_pkg::FI_IRQ, byte_val);
               res1 = mk_read(state_cur.scan_bus, state_cur.scan_devfn,
                              pcse_pkg::REG_PIN, pcse_pkg::SIZE_BYTE);
            end
            pcse_pkg::PH_PIN: begin
               state_nxt.scan_bus      = walk_bus;
               state_nxt.scan_devfn    = walk_devfn;
               state_nxt.pending_phase = walk_phase;
               res_count = 2'd2;
               res0 = mk_report(state_cur.scan_bus, state_cur.scan_devfn,
                                pcse_pkg::REG_PIN, 2'd1, pcse_pkg::SIZE_BYTE,
                                pcse_pkg::FI_PIN, byte_val);
               res1 = walk_res;
            end
            default: begin
               res_count = 2'd0;
            end
         endcase
      end
      // mark the final result of this request
      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end else if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end
   end

endmodule

// File: rtl/pcse_rsp_fifo.sv
// Four-entry result queue taking up to two results per cycle, one out while rsp_chan.ready is high.
// Depends on pcse_pkg and pcse_rsp_if.
module pcse_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  pcse_pkg::rsp_item_type push0,
   input  pcse_pkg::rsp_item_type push1,
   output logic                   has_room,
   pcse_rsp_if.source             rsp_chan
);

   localparam int CntW = pcse_pkg::RSP_PTR_W + 1;

   pcse_pkg::rsp_item_type mem_ff [pcse_pkg::RSP_DEPTH];
   logic [pcse_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcse_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]                count_ff, count_in;
   logic                           pop;
   logic [pcse_pkg::RSP_PTR_W-1:0] wr_ptr_p1;
   pcse_pkg::rsp_item_type         head;

   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign has_room  = (count_ff <= CntW'(pcse_pkg::RSP_DEPTH - 2));
   assign wr_ptr_p1 = wr_ptr_ff + pcse_pkg::RSP_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + push_count[pcse_pkg::RSP_PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + {{(pcse_pkg::RSP_PTR_W-1){1'b0}}, pop};
   assign count_in  = count_ff + CntW'(push_count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push1;
      end
   end

   assign head                    = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.kind           = head.kind;
   assign rsp_chan.config_address = head.config_address;
   assign rsp_chan.byte_lane      = head.byte_lane;
   assign rsp_chan.access_size    = head.access_size;
   assign rsp_chan.field_index    = head.field_index;
   assign rsp_chan.field_value    = head.field_value;
   assign rsp_chan.last           = head.last;

endmodule

// File: rtl/pci_config_space_enumerator_top.sv
// Top level of the PCI configuration space enumerator.
// Depends on pcse_pkg, pcse_req_if, pcse_rsp_if, pcse_walk, pcse_rsp_fifo.
//
// Usage:
//   req_chan  - requests in. cmd 0 starts a scan (abandoning any scan in
//               flight); cmd 1 returns the datum, or a failure flag, for the
//               read last issued. Data with no read pending is dropped.
//   rsp_chan  - results out: read requests (mechanism-1 address, lane, size),
//               device field reports, scan done, scan error. last marks the
//               final result caused by a request; a request gives 0, 1 or 2.
//   csr_wr_en / csr_wr_data - bus_limit, number of buses walked (above 256
//               acts as 256). Write only while the block is idle.
// Results of an accepted request are registered in the result queue before they show on rsp_chan.
// Throughput: one request per cycle while req_chan.ready is high; the walk step,
//   including skipping the unused functions of a single-function device, is one
//   pass of logic. Output bandwidth is one result per cycle, so a stream of
//   two-result requests is held back by req_chan.ready.
// Stall: results sit in a four-entry queue; req_chan.ready drops while
//   fewer than two entries are free, so nothing is lost when rsp stalls.
// Reset: queue emptied, walk idle, bus_limit back to 8.
module pci_config_space_enumerator_top #(
   parameter int BASE_COUNT = 6
) (
   input  logic       clock,
   input  logic       reset,
   pcse_req_if.sink   req_chan,
   pcse_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   // walk state and limit register
   pcse_pkg::walk_state_type state_ff, state_in;
   logic [8:0]               bus_limit_ff;

   pcse_pkg::walk_state_type step_state;
   logic [1:0]               step_count;
   pcse_pkg::rsp_item_type   step_res0;
   pcse_pkg::rsp_item_type   step_res1;
   logic                     has_room;
   logic                     accept;

   assign req_chan.ready = has_room;
   assign accept         = req_chan.valid && req_chan.ready;

   pcse_walk #(
      .BASE_COUNT (BASE_COUNT)
   ) u_walk (
      .state_cur   (state_ff),
      .cmd         (req_chan.cmd),
      .read_data   (req_chan.read_data),
      .read_failed (req_chan.read_failed),
      .bus_limit   (bus_limit_ff),
      .state_nxt   (step_state),
      .res_count   (step_count),
      .res0        (step_res0),
      .res1        (step_res1)
   );

   // state advances only on an accepted request
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.scan_bus      <= '0;
         state_ff.scan_devfn    <= '0;
         state_ff.header_type   <= '0;
         state_ff.pending_phase <= pcse_pkg::PH_IDLE;
         state_ff.bar_slot      <= '0;
         bus_limit_ff           <= pcse_pkg::BUS_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            bus_limit_ff <= csr_wr_data;
         end
      end
   end

   pcse_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (accept ? step_count : 2'd0),
      .push0      (step_res0),
      .push1      (step_res1),
      .has_room   (has_room),
      .rsp_chan   (rsp_chan)
   );

endmodule
